>>> src/hrd_pkg.sv
// hrd_pkg: shared types, constants and pattern tables of the http response deframer
// used by every module under src; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package hrd_pkg;

  localparam int HEADER_LIMIT = 511;
  localparam int PEEK_LIMIT   = 10;
  localparam int HC_W         = $clog2(HEADER_LIMIT + 1);
  localparam int PK_W         = $clog2(PEEK_LIMIT + 1);
  localparam int CQ_DEPTH     = 4;
  localparam int CQ_AW        = $clog2(CQ_DEPTH);

  typedef enum logic [1:0] {
    OP_LINK_OPEN = 2'd0,
    OP_EXPECT    = 2'd1,
    OP_BYTE      = 2'd2,
    OP_TIMEOUT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HEAD = 2'd1,
    PH_BODY = 2'd2,
    PH_PEEK = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BODY = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FAIL = 2'd2
  } kind_t;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NOT_CONN  = 3'd1;
  localparam logic [2:0] ERR_HDR_TMO   = 3'd2;
  localparam logic [2:0] ERR_CLOSED    = 3'd3;
  localparam logic [2:0] ERR_BAD_HDR   = 3'd4;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd5;
  localparam logic [2:0] ERR_BODY_TMO  = 3'd6;

  // status scanner states after the nine prefix characters
  localparam logic [3:0] PFX_LEN    = 4'd9;
  localparam logic [3:0] PFX_SPACE  = 4'd9;
  localparam logic [3:0] PFX_PLUS   = 4'd10;
  localparam logic [3:0] PFX_DIGITS = 4'd11;
  localparam logic [3:0] PFX_DONE   = 4'd12;
  localparam logic [3:0] PFX_BAD    = 4'd13;

  // length scanner states after the fifteen name characters
  localparam logic [4:0] LEN_SPACE  = 5'd15;
  localparam logic [4:0] LEN_PLUS   = 5'd16;
  localparam logic [4:0] LEN_DIGITS = 5'd17;
  localparam logic [4:0] LEN_DONE   = 5'd18;
  localparam logic [4:0] LEN_MINUS  = 5'd19;

  localparam logic [3:0] CLOSED_FULL = 4'd8;
  localparam logic [3:0] CLOSED_WORD = 4'd6;

  localparam logic [31:0] BLANK_LINE = 32'h0D0A0D0A;
  localparam logic [15:0] STATUS_OK  = 16'd200;

  typedef struct packed {
    logic       is_space;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_plus;
    logic       is_minus;
  } byte_class_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    byte_class_t cls;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  body_byte;
    logic [19:0] byte_count;
    logic [15:0] status_value;
    logic [2:0]  error_code;
    logic        link_up;
    logic        last;
  } result_t;

  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    case (idx)
      4'd0: return "H";
      4'd1: return "T";
      4'd2: return "T";
      4'd3: return "P";
      4'd4: return "/";
      4'd5: return "1";
      4'd6: return ".";
      4'd7: return "1";
      default: return " ";
    endcase
  endfunction

  function automatic logic [7:0] closed_char(input logic [2:0] idx);
    case (idx)
      3'd0: return "C";
      3'd1: return "L";
      3'd2: return "O";
      3'd3: return "S";
      3'd4: return "E";
      3'd5: return "D";
      3'd6: return 8'h0D;
      default: return 8'h0A;
    endcase
  endfunction

  // name pattern; lower selects the all lower-case spelling
  function automatic logic [7:0] len_char(input logic [3:0] idx, input logic lower);
    logic [7:0] c;
    case (idx)
      4'd0: c = "C";
      4'd1: c = "o";
      4'd2: c = "n";
      4'd3: c = "t";
      4'd4: c = "e";
      4'd5: c = "n";
      4'd6: c = "t";
      4'd7: c = "-";
      4'd8: c = "L";
      4'd9: c = "e";
      4'd10: c = "n";
      4'd11: c = "g";
      4'd12: c = "t";
      4'd13: c = "h";
      default: c = ":";
    endcase
    if (lower && (idx == 4'd0 || idx == 4'd8)) begin
      c = c | 8'h20;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/hrd_front.sv
// hrd_front: accepts input words, classifies the byte and queues them for the back end
// depends on hrd_pkg
`timescale 1ns / 1ps
`default_nettype none

module hrd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic [1:0]    operation,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          take,
  output logic               head_valid,
  output hrd_pkg::cmd_t      head
);
  import hrd_pkg::*;

  cmd_t             mem [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr;
  logic [CQ_AW-1:0] rd_ptr;
  logic [CQ_AW:0]   count;
  cmd_t             in_cmd;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    in_cmd              = '0;
    in_cmd.op           = op_t'(operation);
    in_cmd.data         = rx_byte;
    in_cmd.cls.is_space = (rx_byte == 8'h20) || (rx_byte >= 8'h09 && rx_byte <= 8'h0D);
    in_cmd.cls.is_digit = (rx_byte >= "0") && (rx_byte <= "9");
    in_cmd.cls.digit    = rx_byte[3:0];
    in_cmd.cls.is_plus  = (rx_byte == "+");
    in_cmd.cls.is_minus = (rx_byte == "-");
  end

  assign full       = (count == (CQ_AW+1)'(CQ_DEPTH));
  assign head_valid = (count != '0);
  assign do_push    = push && !full;
  assign do_pop     = take && head_valid;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/hrd_back.sv
// hrd_back: response state machine with the status, length and closed scanners
// depends on hrd_pkg
`timescale 1ns / 1ps
`default_nettype none

module hrd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write,
  input  wire logic [19:0]   cfg_data,
  input  wire logic          head_valid,
  input  wire hrd_pkg::cmd_t head,
  output logic               take,
  input  wire logic          room,
  output logic               res_valid,
  output hrd_pkg::result_t   res
);
  import hrd_pkg::*;

  typedef struct packed {
    logic [3:0]  idx;
    logic [15:0] acc;
  } pfx_res_t;

  typedef struct packed {
    logic [4:0]  m;
    logic [31:0] v;
  } len_res_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] len;
  } resolve_t;

  function automatic pfx_res_t status_feed(input logic [3:0] s, input logic [15:0] acc,
                                           input logic [7:0] b, input byte_class_t c);
    pfx_res_t    r;
    logic [19:0] t;
    r = '{idx: s, acc: acc};
    t = {1'b0, acc, 3'b0} + {3'b0, acc, 1'b0} + {16'b0, c.digit};
    if (s < PFX_LEN) begin
      r.idx = (b == prefix_char(s)) ? s + 4'd1 : PFX_BAD;
    end else if (s == PFX_SPACE) begin
      if (c.is_space) begin
        r.idx = s;
      end else if (c.is_plus) begin
        r.idx = PFX_PLUS;
      end else if (c.is_minus) begin
        r.acc = '0;
        r.idx = PFX_BAD;
      end else if (c.is_digit) begin
        r.acc = {12'b0, c.digit};
        r.idx = PFX_DIGITS;
      end else begin
        r.idx = PFX_DONE;
      end
    end else if (s == PFX_PLUS || s == PFX_DIGITS) begin
      if (c.is_digit) begin
        if (s == PFX_PLUS) begin
          r.acc = {12'b0, c.digit};
        end else begin
          r.acc = (t > 20'hFFFF) ? 16'hFFFF : t[15:0];
        end
        r.idx = PFX_DIGITS;
      end else begin
        r.idx = PFX_DONE;
      end
    end
    return r;
  endfunction

  function automatic len_res_t length_feed(input logic [4:0] s, input logic [31:0] v,
                                           input logic lower, input logic [7:0] b,
                                           input byte_class_t c);
    len_res_t    r;
    logic [35:0] t;
    r = '{m: s, v: v};
    t = {1'b0, v, 3'b0} + {3'b0, v, 1'b0} + {32'b0, c.digit};
    if (s < LEN_SPACE) begin
      if (b == len_char(s[3:0], lower)) begin
        r.m = s + 5'd1;
      end else begin
        r.m = (b == len_char(4'd0, lower)) ? 5'd1 : 5'd0;
      end
    end else if (s == LEN_SPACE) begin
      if (c.is_space) begin
        r.m = s;
      end else if (c.is_plus) begin
        r.m = LEN_PLUS;
      end else if (c.is_minus) begin
        r.m = LEN_MINUS;
      end else if (c.is_digit) begin
        r.v = {28'b0, c.digit};
        r.m = LEN_DIGITS;
      end else begin
        r.m = LEN_DONE;
      end
    end else if (s == LEN_PLUS || s == LEN_DIGITS) begin
      if (c.is_digit) begin
        if (s == LEN_PLUS) begin
          r.v = {28'b0, c.digit};
        end else begin
          r.v = (t > 36'hFFFFFFFF) ? 32'hFFFFFFFF : t[31:0];
        end
        r.m = LEN_DIGITS;
      end else begin
        r.m = LEN_DONE;
      end
    end
    return r;
  endfunction

  // mixed-case spelling wins over lower case
  function automatic resolve_t resolve(input logic [4:0] um, input logic [31:0] uv,
                                       input logic [4:0] lm, input logic [31:0] lv);
    resolve_t    r;
    logic [4:0]  m;
    logic [31:0] v;
    r = '0;
    m = lm;
    v = lv;
    if (um >= LEN_SPACE) begin
      m = um;
      v = uv;
    end
    if ((um >= LEN_SPACE || lm >= LEN_SPACE) &&
        !(m == LEN_MINUS || m == LEN_SPACE || m == LEN_PLUS)) begin
      r.len = v;
      r.ok  = (v != '0);
    end
    return r;
  endfunction

  function automatic logic [3:0] closed_next(input logic [3:0] idx, input logic [7:0] b);
    if (idx < CLOSED_FULL && b == closed_char(idx[2:0])) begin
      return idx + 4'd1;
    end
    return (b == "C") ? 4'd1 : 4'd0;
  endfunction

  logic [19:0]     max_body_bytes;
  phase_t          phase,        phase_next;
  logic            link_open,    link_open_next;
  logic [31:0]     tail,         tail_next;
  logic [HC_W-1:0] hcount,       hcount_next;
  logic [3:0]      pfx,          pfx_next;
  logic [15:0]     status,       status_next;
  logic [3:0]      cidx,         cidx_next;
  logic [4:0]      um,           um_next;
  logic [4:0]      lm,           lm_next;
  logic [31:0]     uv,           uv_next;
  logic [31:0]     lv,           lv_next;
  logic [19:0]     bcount,       bcount_next;
  logic [PK_W-1:0] pcount,       pcount_next;
  logic            pclosed,      pclosed_next;

  pfx_res_t        pf;
  len_res_t        lu;
  len_res_t        ll;
  logic [3:0]      cn;
  resolve_t        cur;
  resolve_t        hdr;
  logic            scan;
  logic            step;

  assign step = head_valid && room;
  assign take = step;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_bytes <= 20'd4096;
    end else if (cfg_write) begin
      max_body_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      link_open <= 1'b0;
      tail      <= '0;
      hcount    <= '0;
      pfx       <= '0;
      status    <= '0;
      cidx      <= '0;
      um        <= '0;
      lm        <= '0;
      uv        <= '0;
      lv        <= '0;
      bcount    <= '0;
      pcount    <= '0;
      pclosed   <= 1'b0;
    end else begin
      phase     <= phase_next;
      link_open <= link_open_next;
      tail      <= tail_next;
      hcount    <= hcount_next;
      pfx       <= pfx_next;
      status    <= status_next;
      cidx      <= cidx_next;
      um        <= um_next;
      lm        <= lm_next;
      uv        <= uv_next;
      lv        <= lv_next;
      bcount    <= bcount_next;
      pcount    <= pcount_next;
      pclosed   <= pclosed_next;
    end
  end

  always_comb begin
    phase_next     = phase;
    link_open_next = link_open;
    tail_next      = tail;
    hcount_next    = hcount;
    pfx_next       = pfx;
    status_next    = status;
    cidx_next      = cidx;
    um_next        = um;
    lm_next        = lm;
    uv_next        = uv;
    lv_next        = lv;
    bcount_next    = bcount;
    pcount_next    = pcount;
    pclosed_next   = pclosed;
    res_valid      = 1'b0;
    res            = '0;

    pf   = status_feed(pfx, status, head.data, head.cls);
    lu   = length_feed(um, uv, 1'b0, head.data, head.cls);
    ll   = length_feed(lm, lv, 1'b1, head.data, head.cls);
    cn   = closed_next(cidx, head.data);
    cur  = resolve(um, uv, lm, lv);
    scan = (hcount < HC_W'(HEADER_LIMIT));
    hdr  = scan ? resolve(lu.m, lu.v, ll.m, ll.v) : cur;

    if (step) begin
      unique case (head.op)
        OP_LINK_OPEN: begin
          link_open_next = 1'b1;
        end
        OP_EXPECT: begin
          if (!link_open) begin
            res_valid      = 1'b1;
            res.kind       = KIND_FAIL;
            res.error_code = ERR_NOT_CONN;
            res.last       = 1'b1;
            phase_next     = PH_IDLE;
            link_open_next = 1'b0;
          end else begin
            phase_next   = PH_HEAD;
            tail_next    = '0;
            hcount_next  = '0;
            pfx_next     = '0;
            status_next  = '0;
            cidx_next    = '0;
            um_next      = '0;
            lm_next      = '0;
            uv_next      = '0;
            lv_next      = '0;
            bcount_next  = '0;
            pcount_next  = '0;
            pclosed_next = 1'b0;
          end
        end
        OP_TIMEOUT: begin
          unique case (phase)
            PH_HEAD, PH_BODY: begin
              res_valid      = 1'b1;
              res.kind       = KIND_FAIL;
              res.error_code = (phase == PH_HEAD) ? ERR_HDR_TMO : ERR_BODY_TMO;
              res.byte_count = (phase == PH_HEAD) ? 20'd0 : bcount;
              res.last       = 1'b1;
              phase_next     = PH_IDLE;
              link_open_next = 1'b0;
            end
            PH_PEEK: begin
              res_valid        = 1'b1;
              res.kind         = KIND_DONE;
              res.byte_count   = cur.len[19:0];
              res.status_value = status;
              res.link_up      = !pclosed;
              res.last         = 1'b1;
              phase_next       = PH_IDLE;
              link_open_next   = !pclosed;
            end
            default: ;
          endcase
        end
        OP_BYTE: begin
          unique case (phase)
            PH_HEAD: begin
              tail_next = {tail[23:0], head.data};
              if (scan) begin
                hcount_next = hcount + 1'b1;
                pfx_next    = pf.idx;
                status_next = pf.acc;
                um_next     = lu.m;
                uv_next     = lu.v;
                lm_next     = ll.m;
                lv_next     = ll.v;
                cidx_next   = cn;
              end
              if (scan && cn >= CLOSED_FULL) begin
                res_valid      = 1'b1;
                res.kind       = KIND_FAIL;
                res.error_code = ERR_CLOSED;
                res.last       = 1'b1;
                phase_next     = PH_IDLE;
                link_open_next = 1'b0;
              end else if (tail_next == BLANK_LINE) begin
                if (status_next != STATUS_OK || !hdr.ok ||
                    hdr.len > {12'b0, max_body_bytes}) begin
                  res_valid        = 1'b1;
                  res.kind         = KIND_FAIL;
                  res.error_code   = (status_next != STATUS_OK || !hdr.ok) ?
                                     ERR_BAD_HDR : ERR_TOO_LARGE;
                  res.status_value = status_next;
                  res.last         = 1'b1;
                  phase_next       = PH_IDLE;
                  link_open_next   = 1'b0;
                end else begin
                  phase_next  = PH_BODY;
                  bcount_next = '0;
                end
              end
            end
            PH_BODY: begin
              bcount_next   = bcount + 1'b1;
              res_valid     = 1'b1;
              res.kind      = KIND_BODY;
              res.body_byte = head.data;
              res.link_up   = 1'b1;
              if ({12'b0, bcount_next} >= cur.len) begin
                phase_next   = PH_PEEK;
                pcount_next  = '0;
                cidx_next    = '0;
                pclosed_next = 1'b0;
              end
            end
            PH_PEEK: begin
              if (!pclosed) begin
                cidx_next = cn;
                if (cn >= CLOSED_WORD) begin
                  pclosed_next = 1'b1;
                end
              end
              pcount_next = pcount + 1'b1;
              if (pcount_next >= PK_W'(PEEK_LIMIT)) begin
                res_valid        = 1'b1;
                res.kind         = KIND_DONE;
                res.byte_count   = cur.len[19:0];
                res.status_value = status;
                res.link_up      = !pclosed_next;
                res.last         = 1'b1;
                phase_next       = PH_IDLE;
                link_open_next   = !pclosed_next;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/hrd_out_queue.sv
// hrd_out_queue: two-entry result queue that parts the back end from the consumer
// depends on hrd_pkg
`timescale 1ns / 1ps
`default_nettype none

module hrd_out_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             res_valid,
  input  wire hrd_pkg::result_t res,
  output logic                  room,
  output logic                  empty,
  input  wire logic             pop,
  output hrd_pkg::result_t      front
);
  import hrd_pkg::*;

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign room   = (count != 2'd2);
  assign empty  = (count == 2'd0);
  assign do_pop = pop && !empty;
  assign front  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (res_valid) begin
      mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (res_valid && !do_pop) begin
        count <= count + 1'b1;
      end else if (!res_valid && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/http_response_deframer.sv
// http_response_deframer: top level, front queue, response engine and result queue
// depends on hrd_pkg, hrd_front, hrd_back, hrd_out_queue
//
// channel   direction  handshake             payload
// input     in         push / full           operation, rx_byte
// result    out        empty / pop           kind, body_byte, byte_count, status_value,
//                                            error_code, link_up, last
// config    in         cfg_write             cfg_data (max_body_bytes)
//
// one input word per cycle while full is low; any result of a word enters the result queue when the word is taken
// the response engine handles one word per cycle from a four-word input queue
// a full two-entry result queue stalls the engine; the input side keeps filling its queue
// rst clears both queues and the engine, max_body_bytes returns to 4096
`timescale 1ns / 1ps
`default_nettype none

module http_response_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  operation,
  input  wire logic [7:0]  rx_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind,
  output logic [7:0]       body_byte,
  output logic [19:0]      byte_count,
  output logic [15:0]      status_value,
  output logic [2:0]       error_code,
  output logic             link_up,
  output logic             last,
  input  wire logic        cfg_write,
  input  wire logic [19:0] cfg_data
);
  import hrd_pkg::*;

  logic    head_valid;
  cmd_t    head;
  logic    take;
  logic    room;
  logic    res_valid;
  result_t res;
  result_t front;

  hrd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .rx_byte    (rx_byte),
    .take       (take),
    .head_valid (head_valid),
    .head       (head)
  );

  hrd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head       (head),
    .take       (take),
    .room       (room),
    .res_valid  (res_valid),
    .res        (res)
  );

  hrd_out_queue u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .room      (room),
    .empty     (empty),
    .pop       (pop),
    .front     (front)
  );

  assign kind         = front.kind;
  assign body_byte    = front.body_byte;
  assign byte_count   = front.byte_count;
  assign status_value = front.status_value;
  assign error_code   = front.error_code;
  assign link_up      = front.link_up;
  assign last         = front.last;

endmodule

`default_nettype wire

>>> src/hrd_checker.sv
// hrd_checker: port-level checks of the deframer, bound to the top level
// depends on hrd_pkg and http_response_deframer
`timescale 1ns / 1ps
`default_nettype none

module hrd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [1:0]  kind,
  input wire logic [7:0]  body_byte,
  input wire logic [2:0]  error_code,
  input wire logic        link_up,
  input wire logic        last
);
  import hrd_pkg::*;

  // nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // body words carry no error and never end the response
  a_body_word: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_BODY) |-> (!last && error_code == ERR_NONE && link_up))
    else $error("malformed body word");

  // a failure always drops the link and closes the response
  a_fail_word: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_FAIL) |-> (last && !link_up && error_code != ERR_NONE))
    else $error("malformed failure word");

  // a stalled result word holds its data and kind
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(body_byte) && $stable(kind)))
    else $error("waiting result changed");

endmodule

bind http_response_deframer hrd_checker u_hrd_checker (
  .clk        (clk),
  .rst        (rst),
  .empty      (empty),
  .pop        (pop),
  .kind       (kind),
  .body_byte  (body_byte),
  .error_code (error_code),
  .link_up    (link_up),
  .last       (last)
);

`default_nettype wire
